/* design/bbia_pkg.sv */
// Package: sizes, action codes and bitmap helper functions for the block and slot allocator.
`timescale 1ns / 1ps
`default_nettype none
package bbia_pkg;

  localparam int MAX_BLOCKS      = 1024;
  localparam int SLOTS           = 256;
  localparam int RESERVED_BLOCKS = 9;
  localparam int ROOT_SLOT       = 0;

  localparam int IDX_W      = 10;
  localparam int ACT_W      = 3;
  localparam int BLK_CNT_W  = 11;
  localparam int SLOT_CNT_W = 9;

  localparam int WORD_W     = 32;
  localparam int BIT_AW     = $clog2(WORD_W);
  localparam int BLK_WORDS  = MAX_BLOCKS / WORD_W;
  localparam int SLOT_WORDS = SLOTS / WORD_W;
  localparam int BLK_AW     = $clog2(BLK_WORDS);
  localparam int SLOT_AW    = $clog2(SLOT_WORDS);

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_ALLOC_BLK  = 3'd0,
    ACT_FREE_BLK   = 3'd1,
    ACT_ALLOC_SLOT = 3'd2,
    ACT_FREE_SLOT  = 3'd3,
    ACT_FORMAT     = 3'd4
  } action_t;

  // Block word as it stands after reset or format: reserved blocks set.
  function automatic word_t blk_reset_word(input logic [BLK_AW-1:0] w);
    word_t r;
    r = '0;
    for (int i = 0; i < WORD_W; i++) begin
      r[i] = (int'({w, BIT_AW'(i)}) < RESERVED_BLOCKS);
    end
    return r;
  endfunction

  // Slot word after reset or format: only the root slot set.
  function automatic word_t slot_reset_word(input logic [SLOT_AW-1:0] w);
    word_t r;
    r = '0;
    if (w == SLOT_AW'(ROOT_SLOT / WORD_W)) begin
      r[ROOT_SLOT % WORD_W] = 1'b1;
    end
    return r;
  endfunction

  // Lowest clear bit of a word: {found, position}.
  function automatic logic [BIT_AW:0] first_zero(input word_t v);
    logic             found;
    logic [BIT_AW-1:0] pos;
    found = 1'b0;
    pos   = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!v[i]) begin
        found = 1'b1;
        pos   = BIT_AW'(i);
      end
    end
    return {found, pos};
  endfunction

  // Lowest block word that is not full: {found, word address}.
  function automatic logic [BLK_AW:0] first_open_blk(input logic [BLK_WORDS-1:0] full);
    logic              found;
    logic [BLK_AW-1:0] pos;
    found = 1'b0;
    pos   = '0;
    for (int i = BLK_WORDS - 1; i >= 0; i--) begin
      if (!full[i]) begin
        found = 1'b1;
        pos   = BLK_AW'(i);
      end
    end
    return {found, pos};
  endfunction

  // Lowest slot word that is not full: {found, word address}.
  function automatic logic [SLOT_AW:0] first_open_slot(input logic [SLOT_WORDS-1:0] full);
    logic               found;
    logic [SLOT_AW-1:0] pos;
    found = 1'b0;
    pos   = '0;
    for (int i = SLOT_WORDS - 1; i >= 0; i--) begin
      if (!full[i]) begin
        found = 1'b1;
        pos   = SLOT_AW'(i);
      end
    end
    return {found, pos};
  endfunction

endpackage
`default_nettype wire

/* design/bbia_if.sv */
// Interfaces: request and response channels with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface bbia_req_if import bbia_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [IDX_W-1:0] target_index;

  modport source (output valid, action, target_index, input ready);
  modport sink   (input valid, action, target_index, output ready);
endinterface

interface bbia_rsp_if import bbia_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  ok;
  logic [IDX_W-1:0]      granted_index;
  logic [BLK_CNT_W-1:0]  blocks_free;
  logic [SLOT_CNT_W-1:0] slots_free;

  modport source (output valid, ok, granted_index, blocks_free, slots_free, input ready);
  modport sink   (input valid, ok, granted_index, blocks_free, slots_free, output ready);
endinterface
`default_nettype wire

/* design/bbia_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bbia_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* design/bitmap_block_and_inode_allocator.sv */
// Top level: first-fit block and file-slot allocator over word-wide bitmap RAMs.
//
// Usage: requests arrive on req (action, target_index) and each yields one
// response on rsp (ok, granted_index, blocks_free, slots_free); both channels
// transfer on a clock edge with valid and ready high. disk_blocks is written
// through cfg_wen/cfg_wdata while no request is in flight.
// Each map is a RAM of 32-bit words plus a per-word full flag and valid flag
// in flops. A request runs read (pick the word: lowest non-full word for an
// alloc, the target's word for a free), then modify (set the lowest clear bit
// for an alloc or clear the target bit for a free, update counts, write the
// word back). The response turns valid as the modify step commits and
// req.ready returns with it, so requests run one at a time: accept, read, modify.
// The response sits in an output register; the next request is accepted and
// read while it waits, and is held in its modify step until rsp drains.
// Reset and format clear the per-word valid flags at once: a word never
// written since reads as its reset pattern, so no clearing pass is needed.
// Reset also sets disk_blocks to 1024; format keeps it.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_block_and_inode_allocator import bbia_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wen,
  input  wire logic [BLK_CNT_W-1:0] cfg_wdata,
  bbia_req_if.sink                  req,
  bbia_rsp_if.source                rsp
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_MOD} state_t;

  localparam logic [BLK_CNT_W-1:0] MAX_L   = BLK_CNT_W'(MAX_BLOCKS);
  localparam logic [BLK_CNT_W-1:0] RES_CNT = BLK_CNT_W'(RESERVED_BLOCKS);
  localparam logic [IDX_W-1:0]     RES_IDX = IDX_W'(RESERVED_BLOCKS);
  localparam logic [IDX_W:0]       SLOTS_L = (IDX_W + 1)'(SLOTS);
  localparam logic [IDX_W-1:0]     ROOT_L  = IDX_W'(ROOT_SLOT);

  state_t                  state;
  logic [ACT_W-1:0]        act_r;
  logic [IDX_W-1:0]        idx_r;
  logic [BLK_CNT_W-1:0]    disk_blocks;
  logic [BLK_CNT_W-1:0]    free_blk;
  logic [SLOT_CNT_W-1:0]   free_slot;
  logic [BLK_WORDS-1:0]    blk_vld, blk_full;
  logic [SLOT_WORDS-1:0]   slot_vld, slot_full;
  logic [BLK_AW-1:0]       blk_addr_r;
  logic [SLOT_AW-1:0]      slot_addr_r;
  logic                    blk_hit_r, slot_hit_r, blk_rvld, slot_rvld;

  logic                    rsp_valid_r, ok_r;
  logic [IDX_W-1:0]        granted_r;

  logic [BLK_CNT_W-1:0]    bound;
  logic [BLK_AW:0]         blk_srch;
  logic [SLOT_AW:0]        slot_srch;
  logic [BLK_AW-1:0]       blk_rd_addr;
  logic [SLOT_AW-1:0]      slot_rd_addr;
  logic                    rd_en;
  word_t                   blk_q, slot_q, blk_word, slot_word;
  logic [BIT_AW:0]         bz, sz;
  logic [IDX_W-1:0]        blk_gidx, slot_gidx;
  logic [BIT_AW-1:0]       idx_bit;

  logic                    ok_c, fmt_c, blk_we, slot_we, commit;
  logic [IDX_W-1:0]        granted_c;
  word_t                   blk_wdata, slot_wdata;
  logic [BLK_CNT_W-1:0]    free_blk_next, fmt_cnt;
  logic [SLOT_CNT_W-1:0]   free_slot_next;

  assign bound     = (disk_blocks > MAX_L) ? MAX_L : disk_blocks;
  assign blk_srch  = first_open_blk(blk_full);
  assign slot_srch = first_open_slot(slot_full);

  assign rd_en        = (state == S_READ);
  assign blk_rd_addr  = (act_r == ACT_ALLOC_BLK) ? blk_srch[BLK_AW-1:0]
                                                 : idx_r[BIT_AW +: BLK_AW];
  assign slot_rd_addr = (act_r == ACT_ALLOC_SLOT) ? slot_srch[SLOT_AW-1:0]
                                                  : idx_r[BIT_AW +: SLOT_AW];

  bbia_ram #(.DEPTH(BLK_WORDS), .WIDTH(WORD_W)) u_blk_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (blk_rd_addr),
    .rd_data (blk_q),
    .wr_en   (commit && blk_we),
    .wr_addr (blk_addr_r),
    .wr_data (blk_wdata)
  );

  bbia_ram #(.DEPTH(SLOT_WORDS), .WIDTH(WORD_W)) u_slot_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (slot_rd_addr),
    .rd_data (slot_q),
    .wr_en   (commit && slot_we),
    .wr_addr (slot_addr_r),
    .wr_data (slot_wdata)
  );

  // Words never written since reset or format read as their reset pattern.
  assign blk_word  = blk_rvld ? blk_q : blk_reset_word(blk_addr_r);
  assign slot_word = slot_rvld ? slot_q : slot_reset_word(slot_addr_r);
  assign bz        = first_zero(blk_word);
  assign sz        = first_zero(slot_word);
  assign blk_gidx  = {blk_addr_r, bz[BIT_AW-1:0]};
  assign slot_gidx = IDX_W'({slot_addr_r, sz[BIT_AW-1:0]});
  assign idx_bit   = idx_r[BIT_AW-1:0];
  assign fmt_cnt   = (bound > RES_CNT) ? bound - RES_CNT : '0;

  always_comb begin
    ok_c           = 1'b0;
    fmt_c          = 1'b0;
    blk_we         = 1'b0;
    slot_we        = 1'b0;
    granted_c      = '0;
    blk_wdata      = blk_word;
    slot_wdata     = slot_word;
    free_blk_next  = free_blk;
    free_slot_next = free_slot;
    case (act_r)
      ACT_ALLOC_BLK: begin
        if (free_blk != '0 && blk_hit_r && bz[BIT_AW] && {1'b0, blk_gidx} < bound) begin
          ok_c          = 1'b1;
          blk_we        = 1'b1;
          granted_c     = blk_gidx;
          blk_wdata     = blk_word | (WORD_W'(1) << bz[BIT_AW-1:0]);
          free_blk_next = free_blk - 1'b1;
        end
      end
      ACT_FREE_BLK: begin
        if (idx_r >= RES_IDX && {1'b0, idx_r} < bound && blk_word[idx_bit]) begin
          ok_c      = 1'b1;
          blk_we    = 1'b1;
          blk_wdata = blk_word & ~(WORD_W'(1) << idx_bit);
          if (free_blk != '1) begin
            free_blk_next = free_blk + 1'b1;
          end
        end
      end
      ACT_ALLOC_SLOT: begin
        if (free_slot != '0 && slot_hit_r && sz[BIT_AW]) begin
          ok_c           = 1'b1;
          slot_we        = 1'b1;
          granted_c      = slot_gidx;
          slot_wdata     = slot_word | (WORD_W'(1) << sz[BIT_AW-1:0]);
          free_slot_next = free_slot - 1'b1;
        end
      end
      ACT_FREE_SLOT: begin
        if ({1'b0, idx_r} < SLOTS_L && idx_r != ROOT_L && slot_word[idx_bit]) begin
          ok_c       = 1'b1;
          slot_we    = 1'b1;
          slot_wdata = slot_word & ~(WORD_W'(1) << idx_bit);
          if (free_slot != '1) begin
            free_slot_next = free_slot + 1'b1;
          end
        end
      end
      ACT_FORMAT: begin
        ok_c           = 1'b1;
        fmt_c          = 1'b1;
        free_blk_next  = fmt_cnt;
        free_slot_next = SLOT_CNT_W'(SLOTS - 1);
      end
      default: begin
      end
    endcase
  end

  // Hold the modify step while an untaken response occupies the output.
  assign commit = (state == S_MOD) && (!rsp_valid_r || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp_valid_r <= 1'b0;
      disk_blocks <= BLK_CNT_W'(MAX_BLOCKS);
      free_blk    <= (MAX_L > RES_CNT) ? MAX_L - RES_CNT : '0;
      free_slot   <= SLOT_CNT_W'(SLOTS - 1);
      blk_vld     <= '0;
      slot_vld    <= '0;
      for (int w = 0; w < BLK_WORDS; w++) begin
        blk_full[w] <= &blk_reset_word(BLK_AW'(w));
      end
      for (int w = 0; w < SLOT_WORDS; w++) begin
        slot_full[w] <= &slot_reset_word(SLOT_AW'(w));
      end
    end else begin
      if (cfg_wen) begin
        disk_blocks <= cfg_wdata;
      end
      if (rsp_valid_r && rsp.ready && !commit) begin
        rsp_valid_r <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            act_r <= req.action;
            idx_r <= req.target_index;
            state <= S_READ;
          end
        end
        S_READ: begin
          blk_addr_r  <= blk_rd_addr;
          slot_addr_r <= slot_rd_addr;
          blk_hit_r   <= blk_srch[BLK_AW];
          slot_hit_r  <= slot_srch[SLOT_AW];
          blk_rvld    <= blk_vld[blk_rd_addr];
          slot_rvld   <= slot_vld[slot_rd_addr];
          state       <= S_MOD;
        end
        S_MOD: begin
          if (commit) begin
            free_blk    <= free_blk_next;
            free_slot   <= free_slot_next;
            ok_r        <= ok_c;
            granted_r   <= granted_c;
            rsp_valid_r <= 1'b1;
            state       <= S_IDLE;
            if (fmt_c) begin
              blk_vld  <= '0;
              slot_vld <= '0;
              for (int w = 0; w < BLK_WORDS; w++) begin
                blk_full[w] <= &blk_reset_word(BLK_AW'(w));
              end
              for (int w = 0; w < SLOT_WORDS; w++) begin
                slot_full[w] <= &slot_reset_word(SLOT_AW'(w));
              end
            end
            if (blk_we) begin
              blk_vld[blk_addr_r]  <= 1'b1;
              blk_full[blk_addr_r] <= &blk_wdata;
            end
            if (slot_we) begin
              slot_vld[slot_addr_r]  <= 1'b1;
              slot_full[slot_addr_r] <= &slot_wdata;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = rsp_valid_r;
  assign rsp.ok            = ok_r;
  assign rsp.granted_index = granted_r;
  assign rsp.blocks_free   = free_blk;
  assign rsp.slots_free    = free_slot;

  // Free block count never exceeds the number of map blocks above the reserved area.
  a_blk_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    free_blk <= BLK_CNT_W'(MAX_BLOCKS - RESERVED_BLOCKS))
    else $error("free block count above map capacity");

  a_mod_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOD) |-> ($past(state) == S_READ || $past(state) == S_MOD))
    else $error("modify step without a preceding read");

  a_grant_in_range: assert property (@(posedge clk) disable iff (rst)
    (commit && act_r == ACT_ALLOC_BLK && ok_c) |->
      (blk_gidx >= RES_IDX && {1'b0, blk_gidx} < bound))
    else $error("granted block outside the searchable range");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    commit |=> (rsp_valid_r && state == S_IDLE))
    else $error("committed request did not present a response");

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the bitmap block and file-slot allocator.
`timescale 1ns / 1ps
module tb_top;
  import bbia_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int BLK_CNT_MAX  = (1 << BLK_CNT_W) - 1;
  localparam int SLOT_CNT_MAX = (1 << SLOT_CNT_W) - 1;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic                  ok;
    logic [IDX_W-1:0]      granted;
    logic [BLK_CNT_W-1:0]  blocks_free;
    logic [SLOT_CNT_W-1:0] slots_free;
  } grant_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_wen;
  logic [BLK_CNT_W-1:0] cfg_wdata;

  bbia_req_if req ();
  bbia_rsp_if rsp ();

  bitmap_block_and_inode_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // Shadow of the allocator state, updated at each request transfer.
  bit [MAX_BLOCKS-1:0]   blk_map;
  bit [SLOTS-1:0]        slot_map;
  logic [BLK_CNT_W-1:0]  blk_free;
  logic [SLOT_CNT_W-1:0] slot_free;
  logic [BLK_CNT_W-1:0]  disk_blocks;
  grant_t                grant_q[$];

  int errors = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_len = 0;

  function automatic int block_bound();
    return (disk_blocks < MAX_BLOCKS) ? int'(disk_blocks) : MAX_BLOCKS;
  endfunction

  task automatic format_maps();
    int bound;
    bound = block_bound();
    blk_map = '0;
    for (int i = 0; i < RESERVED_BLOCKS; i++) blk_map[i] = 1'b1;
    slot_map = '0;
    slot_map[ROOT_SLOT] = 1'b1;
    blk_free = (bound > RESERVED_BLOCKS) ? BLK_CNT_W'(bound - RESERVED_BLOCKS) : '0;
    slot_free = SLOT_CNT_W'(SLOTS - 1);
  endtask

  // Apply one request to the shadow maps and queue the response it yields.
  task automatic update_maps(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx);
    grant_t g;
    int     bound;
    bit     done;
    g = '0;
    done = 1'b0;
    bound = block_bound();
    case (act)
      ACT_ALLOC_BLK: begin
        if (blk_free != 0) begin
          for (int i = RESERVED_BLOCKS; i < bound && !done; i++) begin
            if (!blk_map[i]) begin
              blk_map[i] = 1'b1;
              blk_free = blk_free - 1'b1;
              g.ok = 1'b1;
              g.granted = IDX_W'(i);
              done = 1'b1;
            end
          end
        end
      end
      ACT_FREE_BLK: begin
        if (idx >= RESERVED_BLOCKS && idx < bound && blk_map[idx]) begin
          blk_map[idx] = 1'b0;
          if (blk_free < BLK_CNT_MAX) blk_free = blk_free + 1'b1;
          g.ok = 1'b1;
        end
      end
      ACT_ALLOC_SLOT: begin
        if (slot_free != 0) begin
          for (int i = 0; i < SLOTS && !done; i++) begin
            if (!slot_map[i]) begin
              slot_map[i] = 1'b1;
              slot_free = slot_free - 1'b1;
              g.ok = 1'b1;
              g.granted = IDX_W'(i);
              done = 1'b1;
            end
          end
        end
      end
      ACT_FREE_SLOT: begin
        if (idx < SLOTS && idx != ROOT_SLOT && slot_map[idx[7:0]]) begin
          slot_map[idx[7:0]] = 1'b0;
          if (slot_free < SLOT_CNT_MAX) slot_free = slot_free + 1'b1;
          g.ok = 1'b1;
        end
      end
      ACT_FORMAT: begin
        format_maps();
        g.ok = 1'b1;
      end
      default: ;
    endcase
    g.blocks_free = blk_free;
    g.slots_free = slot_free;
    grant_q.push_back(g);
  endtask

  // Lowest set entry at or after a random start in [lo, hi), wrapping around.
  function automatic int pick_used(input bit [MAX_BLOCKS-1:0] map, input int lo, input int hi);
    int start;
    int k;
    start = $urandom_range(hi - 1, lo);
    for (int n = 0; n < hi - lo; n++) begin
      k = lo + ((start - lo + n) % (hi - lo));
      if (map[k]) return k;
    end
    return start;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_req(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < send_idle) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.action <= act;
    req.target_index <= idx;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    update_maps(act, idx);
    @(negedge clk);
  endtask

  task automatic settle();
    req.valid <= 1'b0;
    while (grant_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_disk_blocks(input logic [BLK_CNT_W-1:0] v);
    settle();
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    disk_blocks = v;
    @(negedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_item(input int alloc_pct, input int slot_pct, input int fmt_pct);
    int               r;
    bit               on_slots;
    logic [ACT_W-1:0] act;
    logic [IDX_W-1:0] idx;
    r = $urandom_range(99);
    idx = IDX_W'($urandom_range(1023));
    on_slots = ($urandom_range(99) < slot_pct);
    if (r < fmt_pct) begin
      act = ACT_FORMAT;
    end else if (r < fmt_pct + 3) begin
      act = ACT_W'($urandom_range(7, 5));
    end else if ($urandom_range(99) < alloc_pct) begin
      act = on_slots ? ACT_ALLOC_SLOT : ACT_ALLOC_BLK;
    end else begin
      act = on_slots ? ACT_FREE_SLOT : ACT_FREE_BLK;
      // Mostly free something that is in use; the rest is arbitrary.
      if ($urandom_range(99) < 80) begin
        if (on_slots) idx = IDX_W'(pick_used({{(MAX_BLOCKS-SLOTS){1'b0}}, slot_map}, 1, SLOTS));
        else idx = IDX_W'(pick_used(blk_map, RESERVED_BLOCKS, block_bound()));
      end
    end
    send_req(act, idx);
  endtask

  task automatic test_reset_state();
    send_req(ACT_ALLOC_BLK, '1);
    send_req(ACT_ALLOC_SLOT, '0);
    send_req(ACT_FREE_BLK, 10'd0);
    send_req(ACT_FREE_BLK, 10'(RESERVED_BLOCKS - 1));
    send_req(ACT_FREE_BLK, 10'd1023);
    send_req(ACT_FREE_BLK, 10'(RESERVED_BLOCKS));
    send_req(ACT_FREE_SLOT, 10'(ROOT_SLOT));
    send_req(ACT_FREE_SLOT, 10'd1);
    send_req(ACT_FREE_SLOT, 10'd1);
    send_req(ACT_FREE_SLOT, 10'd1023);
    send_req(ACT_W'(5), 10'd1023);
    send_req(ACT_W'(6), 10'd0);
    send_req(ACT_W'(7), 10'd512);
    send_req(ACT_FORMAT, 10'd341);
  endtask

  task automatic test_disk_bounds();
    set_disk_blocks(BLK_CNT_W'(MAX_BLOCKS));
    send_req(ACT_FORMAT, '0);
    send_req(ACT_ALLOC_BLK, '0);
    send_req(ACT_ALLOC_BLK, '0);
    // Shrink the disk without a format: count stays high, search finds nothing.
    set_disk_blocks(11'd10);
    send_req(ACT_ALLOC_BLK, '0);
    send_req(ACT_FREE_BLK, 10'd10);
    send_req(ACT_FREE_BLK, 10'd9);
    send_req(ACT_ALLOC_BLK, '0);
    send_req(ACT_FORMAT, '0);
    send_req(ACT_ALLOC_BLK, '0);
    // Count is zero now: fail without a search.
    send_req(ACT_ALLOC_BLK, '1);
    send_req(ACT_FREE_BLK, 10'd1023);
  endtask

  task automatic test_backpressure();
    settle();
    send_idle = 0;
    hold_len = 300;
    hold_req = hold_req + 1;
    repeat (16) random_item(50, 50, 0);
    send_idle = 75;
  endtask

  task automatic test_random_traffic(input int phases);
    int n;
    int v;
    int ap;
    int sp;
    for (int p = 0; p < phases; p++) begin
      n = $urandom_range(99);
      if (n < 55) v = $urandom_range(64, 10);
      else if (n < 75) v = MAX_BLOCKS;
      else if (n < 85) v = 10;
      else v = $urandom_range(MAX_BLOCKS, 10);
      set_disk_blocks(BLK_CNT_W'(v));
      if ($urandom_range(99) < 70) send_req(ACT_FORMAT, IDX_W'($urandom_range(1023)));
      case ($urandom_range(2))
        0: ap = 85;
        1: ap = 50;
        default: ap = 20;
      endcase
      case ($urandom_range(2))
        0: sp = 15;
        1: sp = 50;
        default: sp = 85;
      endcase
      repeat (50) random_item(ap, sp, 2);
    end
  endtask

  task automatic test_exhaustion();
    set_disk_blocks(11'd40);
    send_req(ACT_FORMAT, '0);
    repeat (80) random_item(90, 10, 0);
    set_disk_blocks(BLK_CNT_W'(MAX_BLOCKS));
    send_req(ACT_FORMAT, '0);
    repeat (300) random_item(95, 90, 0);
  endtask

  // Response receiver: random stalls plus an occasional long hold-off.
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_ack) begin
        rsp.ready <= 1'b0;
        for (int c = 0; c < hold_len; c++) @(negedge clk);
        hold_ack = hold_req;
      end
      rsp.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    grant_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (grant_q.size() == 0) begin
        $display("%0t response with none expected: expected none actual ok=%0d idx=%0d",
                 $time, rsp.ok, rsp.granted_index);
        errors++;
      end else begin
        want = grant_q.pop_front();
        check_field("ok", want.ok, rsp.ok);
        check_field("granted_index", want.granted, rsp.granted_index);
        check_field("blocks_free", want.blocks_free, rsp.blocks_free);
        check_field("slots_free", want.slots_free, rsp.slots_free);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("bitmap_block_and_inode_allocator regression: fail");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    req.valid = 1'b0;
    req.action = '0;
    req.target_index = '0;
    disk_blocks = BLK_CNT_W'(MAX_BLOCKS);
    format_maps();
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle = 9;
    recv_idle = 75;
    test_reset_state();
    test_disk_bounds();
    test_random_traffic(5);

    send_idle = 75;
    recv_idle = 9;
    test_backpressure();
    test_random_traffic(5);

    send_idle = 0;
    recv_idle = 0;
    test_random_traffic(5);
    test_exhaustion();

    settle();
    if (errors == 0) begin
      $display("bitmap_block_and_inode_allocator regression: pass");
    end else begin
      $display("bitmap_block_and_inode_allocator regression: fail");
    end
    $finish;
  end

endmodule
